// ===== sv/ufrb_pkg.sv =====
// ----------------------------------------------------------------------------
// ufrb_pkg
// Shared constants, codes and types for the UART FIFO register block.
// ----------------------------------------------------------------------------
package ufrb_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int BYTE_W     = 8;

   // opcodes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_LINE  = 2'd2;
   localparam logic [1:0] OP_POP   = 2'd3;

   // register selects
   localparam logic [2:0] REG_DATA = 3'd0;
   localparam logic [2:0] REG_STA  = 3'd1;
   localparam logic [2:0] REG_CTB  = 3'd2;
   localparam logic [2:0] REG_CTC  = 3'd3;
   localparam logic [2:0] REG_BDL  = 3'd4;
   localparam logic [2:0] REG_BDH  = 3'd5;

   // status A bits
   localparam logic [7:0] ST_RXC  = 8'h80;
   localparam logic [7:0] ST_TXC  = 8'h40;
   localparam logic [7:0] ST_UDRE = 8'h20;
   localparam logic [7:0] ST_U2X  = 8'h02;
   localparam logic [7:0] ST_MPCM = 8'h01;
   localparam logic [7:0] ST_RESET = ST_UDRE;

   // control B bits
   localparam logic [7:0] CB_RXCIE = 8'h80;
   localparam logic [7:0] CB_UDRIE = 8'h20;
   localparam logic [7:0] CB_RXEN  = 8'h10;
   localparam logic [7:0] CB_TXEN  = 8'h08;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic one_left;     // one pop empties it
      logic almost_full;  // one push fills it
   } fifo_status_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

// ===== sv/uart_fifo_register_block_core.sv =====
// ----------------------------------------------------------------------------
// uart_fifo_register_block_core
// UART register block with receive and transmit ring FIFOs in RAM.
// The result strobe is registered from the execute state that follows acceptance.
// Busy: no new word is taken while one executes; the registered FIFO RAM read of
//   the head word lands in the execute state after acceptance, busy is high during it.
// Reset: synchronous; pointers, registers and status return to reset values.
// The result receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module uart_fifo_register_block_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_opcode,
   input  logic [2:0]                  req_reg_select,
   input  logic [ufrb_pkg::BYTE_W-1:0] req_write_data,
   output logic                        rsp_strobe,
   output logic [ufrb_pkg::BYTE_W-1:0] rsp_read_data,
   output logic                        rsp_tx_notify,
   output logic [ufrb_pkg::BYTE_W-1:0] rsp_tx_notify_byte,
   output logic                        rsp_popped_valid,
   output logic [ufrb_pkg::BYTE_W-1:0] rsp_popped_byte,
   output logic                        rsp_raise_udre_irq,
   output logic                        rsp_raise_rxc_irq
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;

   logic [1:0]                  op_ff;
   logic [2:0]                  sel_ff;
   logic [ufrb_pkg::BYTE_W-1:0] wdata_ff;

   logic [7:0] status_ff, status_in;
   logic [7:0] ctl_b_ff, ctl_b_in;
   logic [7:0] ctl_c_ff, ctl_c_in;
   logic [7:0] baud_lo_ff, baud_lo_in;
   logic [7:0] baud_hi_ff, baud_hi_in;

   logic                        strobe_ff;
   logic [ufrb_pkg::BYTE_W-1:0] rdata_ff, rdata_in;
   logic                        txn_ff, txn_in;
   logic [ufrb_pkg::BYTE_W-1:0] txn_byte_ff, txn_byte_in;
   logic                        pop_v_ff, pop_v_in;
   logic [ufrb_pkg::BYTE_W-1:0] pop_byte_ff, pop_byte_in;
   logic                        udre_irq_ff, udre_irq_in;
   logic                        rxc_irq_ff, rxc_irq_in;

   ufrb_pkg::fifo_ctrl_type     rx_ctrl, tx_ctrl;
   ufrb_pkg::fifo_status_type   rx_st, tx_st;
   logic [ufrb_pkg::BYTE_W-1:0] rx_head, tx_head;

   logic accept, exec;
   logic is_read, is_write, is_line, is_pop;
   logic rx_pop, tx_push_try, rx_push_try, tx_pop, upd;
   logic tx_full_post, rx_empty_post;
   logic [7:0] st_work;

   assign busy   = (state_ff == S_EXEC);
   assign accept = start && !busy;
   assign exec   = (state_ff == S_EXEC);

   assign is_read  = exec && (op_ff == ufrb_pkg::OP_READ);
   assign is_write = exec && (op_ff == ufrb_pkg::OP_WRITE);
   assign is_line  = exec && (op_ff == ufrb_pkg::OP_LINE);
   assign is_pop   = exec && (op_ff == ufrb_pkg::OP_POP);

   assign rx_pop      = is_read && (sel_ff == ufrb_pkg::REG_DATA) && !rx_st.empty;
   assign tx_push_try = is_write && (sel_ff == ufrb_pkg::REG_DATA)
                        && ((ctl_b_ff & ufrb_pkg::CB_TXEN) != 8'h00);
   assign rx_push_try = is_line && ((ctl_b_ff & ufrb_pkg::CB_RXEN) != 8'h00);
   assign tx_pop      = is_pop && !tx_st.empty;

   assign upd = rx_pop || tx_push_try || rx_push_try
                || (is_read && (sel_ff == ufrb_pkg::REG_STA))
                || (is_write && (sel_ff == ufrb_pkg::REG_CTB));

   assign rx_ctrl.push = rx_push_try;
   assign rx_ctrl.pop  = rx_pop;
   assign tx_ctrl.push = tx_push_try;
   assign tx_ctrl.pop  = tx_pop;

   assign tx_full_post  = tx_push_try ? tx_st.almost_full || tx_st.full : tx_st.full;
   assign rx_empty_post = rx_push_try ? 1'b0 : (rx_pop ? rx_st.one_left : rx_st.empty);

   always_comb begin
      state_in    = state_ff;
      status_in   = status_ff;
      ctl_b_in    = ctl_b_ff;
      ctl_c_in    = ctl_c_ff;
      baud_lo_in  = baud_lo_ff;
      baud_hi_in  = baud_hi_ff;
      rdata_in    = '0;
      txn_in      = 1'b0;
      txn_byte_in = '0;
      pop_v_in    = tx_pop;
      pop_byte_in = tx_pop ? tx_head : '0;
      udre_irq_in = 1'b0;
      rxc_irq_in  = 1'b0;
      st_work     = status_ff;

      if (accept) begin
         state_in = S_EXEC;
      end else if (exec) begin
         state_in = S_IDLE;
      end

      if (is_write) begin
         unique case (sel_ff)
            ufrb_pkg::REG_STA: begin
               if ((wdata_ff & ufrb_pkg::ST_TXC) != 8'h00) begin
                  st_work = st_work & ~ufrb_pkg::ST_TXC;
               end
               st_work = (st_work & ~(ufrb_pkg::ST_U2X | ufrb_pkg::ST_MPCM))
                         | (wdata_ff & (ufrb_pkg::ST_U2X | ufrb_pkg::ST_MPCM));
            end
            ufrb_pkg::REG_CTB: ctl_b_in   = wdata_ff;
            ufrb_pkg::REG_CTC: ctl_c_in   = wdata_ff;
            ufrb_pkg::REG_BDL: baud_lo_in = wdata_ff;
            ufrb_pkg::REG_BDH: baud_hi_in = wdata_ff;
            default: ;
         endcase
      end

      if (tx_push_try) begin
         st_work     = st_work | ufrb_pkg::ST_TXC;
         txn_in      = 1'b1;
         txn_byte_in = wdata_ff;
      end

      if (upd) begin
         st_work = tx_full_post ? (st_work & ~ufrb_pkg::ST_UDRE)
                                : (st_work | ufrb_pkg::ST_UDRE);
         st_work = rx_empty_post ? (st_work & ~ufrb_pkg::ST_RXC)
                                 : (st_work | ufrb_pkg::ST_RXC);
         udre_irq_in = !tx_full_post && ((ctl_b_in & ufrb_pkg::CB_UDRIE) != 8'h00);
         rxc_irq_in  = !rx_empty_post && ((ctl_b_in & ufrb_pkg::CB_RXCIE) != 8'h00);
      end
      status_in = st_work;

      if (is_read) begin
         unique case (sel_ff)
            ufrb_pkg::REG_DATA: rdata_in = rx_pop ? rx_head : '0;
            ufrb_pkg::REG_STA:  rdata_in = st_work;
            ufrb_pkg::REG_CTB:  rdata_in = ctl_b_ff;
            ufrb_pkg::REG_CTC:  rdata_in = ctl_c_ff;
            ufrb_pkg::REG_BDL:  rdata_in = baud_lo_ff;
            ufrb_pkg::REG_BDH:  rdata_in = baud_hi_ff;
            default:            rdata_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         status_ff  <= ufrb_pkg::ST_RESET;
         ctl_b_ff   <= '0;
         ctl_c_ff   <= '0;
         baud_lo_ff <= '0;
         baud_hi_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         status_ff  <= status_in;
         ctl_b_ff   <= ctl_b_in;
         ctl_c_ff   <= ctl_c_in;
         baud_lo_ff <= baud_lo_in;
         baud_hi_ff <= baud_hi_in;
         strobe_ff  <= exec;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         sel_ff   <= req_reg_select;
         wdata_ff <= req_write_data;
      end
      if (exec) begin
         rdata_ff    <= rdata_in;
         txn_ff      <= txn_in;
         txn_byte_ff <= txn_byte_in;
         pop_v_ff    <= pop_v_in;
         pop_byte_ff <= pop_byte_in;
         udre_irq_ff <= udre_irq_in;
         rxc_irq_ff  <= rxc_irq_in;
      end
   end

   ufrb_fifo u_rx_fifo (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (rx_ctrl),
      .push_data(wdata_ff),
      .head_data(rx_head),
      .status   (rx_st)
   );

   ufrb_fifo u_tx_fifo (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (tx_ctrl),
      .push_data(wdata_ff),
      .head_data(tx_head),
      .status   (tx_st)
   );

   assign rsp_strobe         = strobe_ff;
   assign rsp_read_data      = rdata_ff;
   assign rsp_tx_notify      = txn_ff;
   assign rsp_tx_notify_byte = txn_byte_ff;
   assign rsp_popped_valid   = pop_v_ff;
   assign rsp_popped_byte    = pop_byte_ff;
   assign rsp_raise_udre_irq = udre_irq_ff;
   assign rsp_raise_rxc_irq  = rxc_irq_ff;

`ifndef SYNTHESIS
   a_exec_then_result: assert property (@(posedge clock) disable iff (reset)
      exec |=> (rsp_strobe && !busy))
      else $error("execute cycle not followed by result");

   a_single_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_tx_notify && rsp_popped_valid))
      else $error("push notify and pop in one result");

   a_status_reserved: assert property (@(posedge clock) disable iff (reset)
      (status_ff[4:3] == 2'b00))
      else $error("reserved status bits set");

   a_fifo_never_both: assert property (@(posedge clock) disable iff (reset)
      !(rx_st.empty && rx_st.full) && !(tx_st.empty && tx_st.full))
      else $error("FIFO both empty and full");
`endif

endmodule

// ===== sv/ufrb_ram.sv =====
// ----------------------------------------------------------------------------
// ufrb_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ufrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ufrb_fifo.sv =====
// ----------------------------------------------------------------------------
// ufrb_fifo
// Ring FIFO: write/read pointers around a RAM. Holds depth minus one words.
// Read data shows the word at the read pointer one cycle after it settles.
// ----------------------------------------------------------------------------
module ufrb_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  ufrb_pkg::fifo_ctrl_type       ctrl,
   input  logic [ufrb_pkg::BYTE_W-1:0]   push_data,
   output logic [ufrb_pkg::BYTE_W-1:0]   head_data,
   output ufrb_pkg::fifo_status_type     status
);

   logic [ufrb_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ufrb_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ufrb_pkg::PTR_W-1:0] wr_ptr_nx, rd_ptr_nx;

   assign wr_ptr_nx = ufrb_pkg::ptr_next(wr_ptr_ff);
   assign rd_ptr_nx = ufrb_pkg::ptr_next(rd_ptr_ff);

   always_comb begin
      status.empty       = (wr_ptr_ff == rd_ptr_ff);
      status.full        = (wr_ptr_nx == rd_ptr_ff);
      status.one_left    = (rd_ptr_nx == wr_ptr_ff);
      status.almost_full = (ufrb_pkg::ptr_next(wr_ptr_nx) == rd_ptr_ff);
   end

   assign wr_ptr_in = (ctrl.push && !status.full) ? wr_ptr_nx : wr_ptr_ff;
   assign rd_ptr_in = (ctrl.pop && !status.empty) ? rd_ptr_nx : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   ufrb_ram #(
      .WIDTH(ufrb_pkg::BYTE_W),
      .DEPTH(ufrb_pkg::FIFO_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ctrl.push && !status.full),
      .wr_addr(wr_ptr_ff),
      .wr_data(push_data),
      .rd_addr(rd_ptr_ff),
      .rd_data(head_data)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UART FIFO register block.
// A shadow copy of the registers and both ring FIFOs predicts every response
// word. A short directed sequence comes first. Randomized traffic follows in
// three pacing modes, made of bursts that fill and drain the FIFOs, control
// B reprogramming and mixed register access.
// ----------------------------------------------------------------------------
module tb;
   import ufrb_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int WORDS_PHASE  = 625;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [1:0]        op;
      logic [2:0]        sel;
      logic [BYTE_W-1:0] data;
   } uart_word_t;

   typedef struct packed {
      logic [BYTE_W-1:0] rd;
      logic              txn;
      logic [BYTE_W-1:0] txb;
      logic              pv;
      logic [BYTE_W-1:0] pb;
      logic              udre_irq;
      logic              rxc_irq;
   } uart_rsp_t;

   typedef enum {BURST_TX, BURST_RX, DRAIN_TX, DRAIN_RX, MIXED} episode_t;

   logic              clock;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_opcode = OP_READ;
   logic [2:0]        req_reg_select = REG_DATA;
   logic [BYTE_W-1:0] req_write_data = '0;
   logic              rsp_strobe;
   logic [BYTE_W-1:0] rsp_read_data;
   logic              rsp_tx_notify;
   logic [BYTE_W-1:0] rsp_tx_notify_byte;
   logic              rsp_popped_valid;
   logic [BYTE_W-1:0] rsp_popped_byte;
   logic              rsp_raise_udre_irq;
   logic              rsp_raise_rxc_irq;

   uart_word_t bus_words[$];
   uart_rsp_t  expected_rsps[$];
   uart_word_t next_word;
   logic       took_word = 1'b0;
   int         send_gap_pct = 0;
   int         words_queued = 0;
   int         stall_cycles = 0;
   int         mismatches = 0;
   int         rsps_checked = 0;
   int         op_count[4] = '{default: 0};
   int         drops = 0;
   int         udre_irqs = 0;
   int         rxc_irqs = 0;

   // shadow of the block
   logic [BYTE_W-1:0] rx_mem[FIFO_DEPTH];
   logic [BYTE_W-1:0] tx_mem[FIFO_DEPTH];
   int                rx_wp = 0, rx_rp = 0, tx_wp = 0, tx_rp = 0;
   logic [BYTE_W-1:0] status_shadow = ST_RESET;
   logic [BYTE_W-1:0] ctl_b = '0, ctl_c = '0, baud_lo = '0, baud_hi = '0;

   uart_fifo_register_block_core uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_reg_select     (req_reg_select),
      .req_write_data     (req_write_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_read_data      (rsp_read_data),
      .rsp_tx_notify      (rsp_tx_notify),
      .rsp_tx_notify_byte (rsp_tx_notify_byte),
      .rsp_popped_valid   (rsp_popped_valid),
      .rsp_popped_byte    (rsp_popped_byte),
      .rsp_raise_udre_irq (rsp_raise_udre_irq),
      .rsp_raise_rxc_irq  (rsp_raise_rxc_irq)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int ring_next(input int p);
      return (p + 1 == FIFO_DEPTH) ? 0 : p + 1;
   endfunction

   function automatic bit ring_at_cap(input int w, input int r);
      int used;
      used = (w >= r) ? w - r : w + FIFO_DEPTH - r;
      return used >= FIFO_DEPTH - 1;
   endfunction

   task automatic refresh_status(inout uart_rsp_t r);
      if (!ring_at_cap(tx_wp, tx_rp))
         status_shadow = status_shadow | ST_UDRE;
      else
         status_shadow = status_shadow & ~ST_UDRE;
      if (rx_wp != rx_rp)
         status_shadow = status_shadow | ST_RXC;
      else
         status_shadow = status_shadow & ~ST_RXC;
      if ((status_shadow & ST_UDRE) != 0 && (ctl_b & CB_UDRIE) != 0)
         r.udre_irq = 1'b1;
      if ((status_shadow & ST_RXC) != 0 && (ctl_b & CB_RXCIE) != 0)
         r.rxc_irq = 1'b1;
   endtask

   task automatic predict_uart_step(input uart_word_t w, output uart_rsp_t r);
      logic [BYTE_W-1:0] keep_mask;
      r = '0;
      keep_mask = ~(ST_U2X | ST_MPCM);
      case (w.op)
         OP_READ: begin
            case (w.sel)
               REG_DATA: begin
                  if (rx_wp != rx_rp) begin
                     r.rd = rx_mem[rx_rp];
                     rx_rp = ring_next(rx_rp);
                     refresh_status(r);
                  end
               end
               REG_STA: begin
                  refresh_status(r);
                  r.rd = status_shadow;
               end
               REG_CTB: r.rd = ctl_b;
               REG_CTC: r.rd = ctl_c;
               REG_BDL: r.rd = baud_lo;
               REG_BDH: r.rd = baud_hi;
               default: r.rd = '0;
            endcase
         end
         OP_WRITE: begin
            case (w.sel)
               REG_DATA: begin
                  if ((ctl_b & CB_TXEN) != 0) begin
                     if (!ring_at_cap(tx_wp, tx_rp)) begin
                        tx_mem[tx_wp] = w.data;
                        tx_wp = ring_next(tx_wp);
                     end else
                        drops++;
                     status_shadow = status_shadow | ST_TXC;
                     r.txn = 1'b1;
                     r.txb = w.data;
                     refresh_status(r);
                  end
               end
               REG_STA: begin
                  if ((w.data & ST_TXC) != 0)
                     status_shadow = status_shadow & ~ST_TXC;
                  status_shadow = (status_shadow & keep_mask) | (w.data & ~keep_mask);
               end
               REG_CTB: begin
                  ctl_b = w.data;
                  refresh_status(r);
               end
               REG_CTC: ctl_c = w.data;
               REG_BDL: baud_lo = w.data;
               REG_BDH: baud_hi = w.data;
               default: ;
            endcase
         end
         OP_LINE: begin
            if ((ctl_b & CB_RXEN) != 0) begin
               if (!ring_at_cap(rx_wp, rx_rp)) begin
                  rx_mem[rx_wp] = w.data;
                  rx_wp = ring_next(rx_wp);
               end else
                  drops++;
               refresh_status(r);
            end
         end
         default: begin
            if (tx_wp != tx_rp) begin
               r.pv = 1'b1;
               r.pb = tx_mem[tx_rp];
               tx_rp = ring_next(tx_rp);
            end
         end
      endcase
      udre_irqs += r.udre_irq;
      rxc_irqs += r.rxc_irq;
   endtask

   task automatic add_word(input logic [1:0] op, input logic [2:0] sel,
                           input logic [BYTE_W-1:0] data);
      uart_word_t w;
      w.op = op;
      w.sel = sel;
      w.data = data;
      bus_words.push_back(w);
      words_queued++;
   endtask

   task automatic add_directed_words();
      add_word(OP_READ, REG_STA, 8'h00);
      add_word(OP_READ, REG_DATA, 8'h00);
      add_word(OP_WRITE, REG_DATA, 8'hA5);
      add_word(OP_LINE, REG_DATA, 8'h5A);
      add_word(OP_POP, REG_DATA, 8'h00);
      add_word(OP_READ, REG_CTB, 8'h00);
      add_word(OP_WRITE, REG_CTB, CB_RXCIE | CB_UDRIE | CB_RXEN | CB_TXEN);
      add_word(OP_WRITE, REG_DATA, 8'hFF);
      add_word(OP_WRITE, REG_DATA, 8'h00);
      add_word(OP_LINE, 3'd7, 8'hFF);
      add_word(OP_LINE, REG_DATA, 8'h00);
      add_word(OP_READ, REG_STA, 8'h00);
      add_word(OP_WRITE, REG_STA, 8'hFF);
      add_word(OP_READ, REG_STA, 8'h00);
      add_word(OP_WRITE, REG_STA, 8'h00);
      add_word(OP_READ, REG_DATA, 8'h00);
      add_word(OP_POP, 3'd7, 8'hFF);
      add_word(OP_WRITE, REG_CTC, 8'hFF);
      add_word(OP_WRITE, REG_BDL, 8'hFF);
      add_word(OP_WRITE, REG_BDH, 8'h80);
      add_word(OP_READ, REG_CTC, 8'h00);
      add_word(OP_READ, REG_BDL, 8'h00);
      add_word(OP_READ, REG_BDH, 8'h00);
      add_word(OP_WRITE, 3'd7, 8'hFF);
      add_word(OP_READ, 3'd6, 8'h00);
   endtask

   // bursts of up to 24 words, enough to fill a FIFO, drains, and mixed access
   task automatic add_random_words(input int count);
      int target, len, k, pick;
      episode_t kind;
      logic [BYTE_W-1:0] cb;
      target = words_queued + count;
      while (words_queued < target) begin
         if ($urandom_range(9) == 0) begin
            cb = BYTE_W'($urandom_range(255));
            if ($urandom_range(4) != 0)
               cb = cb | CB_RXEN | CB_TXEN;
            add_word(OP_WRITE, REG_CTB, cb);
         end
         pick = $urandom_range(6);
         kind = (pick > 4) ? MIXED : episode_t'(pick);
         len = $urandom_range(24, 4);
         for (k = 0; k < len; k++) begin
            case (kind)
               BURST_TX: add_word(OP_WRITE, REG_DATA, BYTE_W'($urandom_range(255)));
               BURST_RX: add_word(OP_LINE, 3'($urandom_range(7)),
                                  BYTE_W'($urandom_range(255)));
               DRAIN_TX: add_word(OP_POP, 3'($urandom_range(7)),
                                  BYTE_W'($urandom_range(255)));
               DRAIN_RX: add_word(OP_READ, ($urandom_range(3) == 0) ? REG_STA : REG_DATA,
                                  BYTE_W'($urandom_range(255)));
               default: add_word(2'($urandom_range(3)), 3'($urandom_range(7)),
                                 BYTE_W'($urandom_range(255)));
            endcase
         end
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!start || took_word) begin
            if (bus_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               next_word = bus_words.pop_front();
               req_opcode <= next_word.op;
               req_reg_select <= next_word.sel;
               req_write_data <= next_word.data;
               start <= 1'b1;
            end else
               start <= 1'b0;
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      uart_rsp_t got, want;
      uart_word_t acc;
      if (reset)
         took_word <= 1'b0;
      else begin
         took_word <= start && !busy;
         if (rsp_strobe) begin
            got = '{rsp_read_data, rsp_tx_notify, rsp_tx_notify_byte, rsp_popped_valid,
                    rsp_popped_byte, rsp_raise_udre_irq, rsp_raise_rxc_irq};
            if (expected_rsps.size() == 0) begin
               if (mismatches < 10)
                  $display({"ERROR: unexpected response word",
                            " rd=%h txn=%b txb=%h pv=%b pb=%h udre=%b rxc=%b"},
                           got.rd, got.txn, got.txb, got.pv, got.pb, got.udre_irq, got.rxc_irq);
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               rsps_checked++;
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display("ERROR: response %0d mismatch", rsps_checked);
                     $display("  exp rd=%h txn=%b txb=%h pv=%b pb=%h udre=%b rxc=%b",
                              want.rd, want.txn, want.txb, want.pv, want.pb,
                              want.udre_irq, want.rxc_irq);
                     $display("  got rd=%h txn=%b txb=%h pv=%b pb=%h udre=%b rxc=%b",
                              got.rd, got.txn, got.txb, got.pv, got.pb,
                              got.udre_irq, got.rxc_irq);
                  end
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            acc.op = req_opcode;
            acc.sel = req_reg_select;
            acc.data = req_write_data;
            op_count[acc.op]++;
            predict_uart_step(acc, want);
            expected_rsps.push_back(want);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe)
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int gap_pct[3];
      int phase;
      gap_pct = '{13, 87, 0};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < 3; phase++) begin
         send_gap_pct = gap_pct[phase];
         if (phase == 0)
            add_directed_words();
         add_random_words(WORDS_PHASE);
         while (bus_words.size() != 0 || start)
            @(posedge clock);
      end
      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $display("ERROR: %0d response words never arrived", expected_rsps.size());
         mismatches += expected_rsps.size();
      end
      $display("Covered %0d words: %0d reads, %0d writes, %0d line bytes, %0d pops",
               words_queued, op_count[OP_READ], op_count[OP_WRITE], op_count[OP_LINE],
               op_count[OP_POP]);
      $display("Checked %0d responses, %0d full-FIFO drops, %0d UDRE / %0d RXC irqs",
               rsps_checked, drops, udre_irqs, rxc_irqs);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
